FILE: rtl/sprseq_pkg.sv
// Package for the sprite frame sequencer.
// Holds shared types, field widths, action and register codes.
// Used by every module of the block but sprseq_ram; depends on nothing.
package sprseq_pkg;

    localparam int MAX_FRAMES = 16;

    localparam int ACTION_W   = 3;
    localparam int STEP_W     = 20;
    localparam int SLOT_W     = 4;
    localparam int DUR_IN_W   = 24;
    localparam int FRAME_W    = 4;
    localparam int PRIOR_W    = 5;
    localparam int LOOP_W     = 16;
    localparam int ELAPSED_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int COUNT_W    = 5;

    localparam logic [ACTION_W-1:0] ACT_TICK  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_WRITE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PLAY  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_PAUSE = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_STOP  = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_SEEK  = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COUNT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOOP_ENABLE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REWIND_AT_END = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_CHECK,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic advance;
        logic load_rem;
        logic div_start;
        logic div_step;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic tick_active;
        logic acc_ge_dur;
        logic dur_zero;
        logic div_last;
    } status_t;

endpackage

FILE: rtl/sprseq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Parameters set width and depth; no other dependencies.
module sprseq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sprseq_ctrl.sv
// Controller state machine of the sprite frame sequencer.
// Issues commands to the datapath and owns the handshake; uses sprseq_pkg.
module sprseq_ctrl
    import sprseq_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                state_next = status.tick_active ? ST_CHECK : ST_OUT;
            end
            ST_CHECK: begin
                if (status.acc_ge_dur && !status.dur_zero) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV: begin
                if (status.div_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd          = '0;
        s_ready      = 1'b0;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_DECODE: begin
                cmd.exec = 1'b1;
            end
            ST_CHECK: begin
                cmd.advance   = status.acc_ge_dur && status.dur_zero;
                cmd.div_start = status.acc_ge_dur && !status.dur_zero;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            ST_FINISH: begin
                cmd.advance  = 1'b1;
                cmd.load_rem = 1'b1;
            end
            ST_OUT: begin
                cmd.load_out = out_free;
                if (out_free) begin
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    assign m_valid = m_valid_reg;

endmodule

FILE: rtl/sprseq_dpath.sv
// Datapath of the sprite frame sequencer: configuration, playback state,
// duration table with valid bits, serial remainder unit and result register.
// Uses sprseq_pkg and sprseq_ram.
module sprseq_dpath
    import sprseq_pkg::*;
#(
    parameter int TIME_BITS  = 24
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_wdata,
    input  logic [ACTION_W-1:0]          s_action,
    input  logic [STEP_W-1:0]            s_step_us,
    input  logic [SLOT_W-1:0]            s_slot,
    input  logic [DUR_IN_W-1:0]          s_duration_us,
    input  cmd_t                         cmd,
    output status_t                      status,
    output logic [FRAME_W-1:0]           m_frame,
    output logic signed [PRIOR_W-1:0]    m_prior_frame,
    output logic                         m_advanced,
    output logic                         m_done_flag,
    output logic                         m_halted,
    output logic [LOOP_W-1:0]            m_loops,
    output logic [ELAPSED_W-1:0]         m_elapsed_us
);

    localparam int AW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int ACC_W  = TIME_BITS + 1;
    localparam int SUM_W  = ((ACC_W > STEP_W) ? ACC_W : STEP_W) + 1;
    localparam int CNT_W  = $clog2(TIME_BITS + 2);
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    // Configuration registers.
    logic [COUNT_W-1:0] frame_count_reg;
    logic               loop_enable_reg;
    logic               rewind_reg;

    // Captured item.
    logic [ACTION_W-1:0]  action_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [DUR_IN_W-1:0]  dur_in_reg;

    // Playback state.
    logic [FRAME_W-1:0]        frame_reg, frame_next;
    logic signed [PRIOR_W-1:0] prior_reg, prior_next;
    logic [ACC_W-1:0]          acc_reg, acc_next;
    logic                      paused_reg, paused_next;
    logic                      finished_reg, finished_next;
    logic [LOOP_W-1:0]         loops_reg, loops_next;
    logic [ELAPSED_W-1:0]      elapsed_reg, elapsed_next;
    logic                      adv_reg, adv_next;
    logic [MAX_FRAMES-1:0]     valid_reg, valid_next;

    // Table read and remainder unit.
    logic                  rd_ok_reg;
    logic [TIME_BITS-1:0]  rd_data;
    logic [TIME_BITS-1:0]  dur_eff;
    logic [ACC_W-1:0]      rem_reg, rem_next;
    logic [ACC_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [ACC_W-1:0]      shifted;

    // Result register.
    logic [FRAME_W-1:0]        out_frame_reg;
    logic signed [PRIOR_W-1:0] out_prior_reg;
    logic                      out_adv_reg;
    logic                      out_done_reg;
    logic                      out_halt_reg;
    logic [LOOP_W-1:0]         out_loops_reg;
    logic [ELAPSED_W-1:0]      out_elapsed_reg;

    logic [COUNT_W-1:0] count_eff;
    logic [SUM_W-1:0]   sum;
    logic [ACC_W-1:0]   acc_sat;
    logic               slot_ok;
    logic               ram_we;
    logic [AW-1:0]      frame_addr;
    logic [AW-1:0]      slot_addr;

    assign count_eff  = (32'(frame_count_reg) > MAX_FRAMES) ? COUNT_W'(MAX_FRAMES)
                                                            : frame_count_reg;
    assign frame_addr = AW'(frame_reg);
    assign slot_addr  = AW'(slot_reg);
    assign slot_ok    = 32'(slot_reg) < MAX_FRAMES;
    assign ram_we     = cmd.exec && (action_reg == ACT_WRITE) && slot_ok;

    assign sum     = SUM_W'(acc_reg) + SUM_W'(step_reg);
    assign acc_sat = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : ACC_W'(sum);
    assign dur_eff = rd_ok_reg ? rd_data : '0;
    assign shifted = {rem_reg[ACC_W-2:0], quo_reg[ACC_W-1]};

    assign status.tick_active = (action_reg == ACT_TICK) && (count_eff != '0) && !paused_reg;
    assign status.acc_ge_dur  = acc_reg >= ACC_W'(dur_eff);
    assign status.dur_zero    = (dur_eff == '0);
    assign status.div_last    = (cnt_reg == CNT_W'(1));

    sprseq_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (MAX_FRAMES),
        .AW    (AW)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (slot_addr),
        .wdata (TIME_BITS'(dur_in_reg)),
        .raddr (frame_addr),
        .rdata (rd_data)
    );

    always_comb begin
        frame_next    = frame_reg;
        prior_next    = prior_reg;
        acc_next      = acc_reg;
        paused_next   = paused_reg;
        finished_next = finished_reg;
        loops_next    = loops_reg;
        elapsed_next  = elapsed_reg;
        adv_next      = adv_reg;
        valid_next    = valid_reg;
        if (cmd.exec) begin
            adv_next = 1'b0;
            case (action_reg)
                ACT_TICK: begin
                    if (status.tick_active) begin
                        finished_next = 1'b0;
                        prior_next    = PRIOR_W'(frame_reg);
                        acc_next      = acc_sat;
                        elapsed_next  = elapsed_reg + ELAPSED_W'(step_reg);
                    end
                end
                ACT_WRITE: begin
                    if (slot_ok) begin
                        valid_next[slot_addr] = 1'b1;
                    end
                end
                ACT_PLAY: begin
                    paused_next = 1'b0;
                end
                ACT_PAUSE: begin
                    paused_next = 1'b1;
                end
                ACT_STOP: begin
                    paused_next = 1'b1;
                    prior_next  = '1;
                    frame_next  = '0;
                    acc_next    = '0;
                end
                ACT_SEEK: begin
                    prior_next = '1;
                    frame_next = '0;
                    acc_next   = '0;
                end
                default: begin
                    adv_next = 1'b0;
                end
            endcase
        end
        if (cmd.advance) begin
            adv_next = 1'b1;
            if (cmd.load_rem) begin
                acc_next = rem_reg;
            end
            if ((COUNT_W'(frame_reg) + COUNT_W'(1)) < count_eff) begin
                frame_next = frame_reg + FRAME_W'(1);
            end else begin
                finished_next = 1'b1;
                if (rewind_reg) begin
                    frame_next = '0;
                end
                if (loop_enable_reg) begin
                    if (loops_reg != '1) begin
                        loops_next = loops_reg + LOOP_W'(1);
                    end
                end else begin
                    paused_next = 1'b1;
                end
            end
        end
    end

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (cmd.div_start) begin
            rem_next = '0;
            quo_next = acc_reg;
            cnt_next = CNT_W'(ACC_W);
        end else if (cmd.div_step) begin
            rem_next = (shifted >= ACC_W'(dur_eff)) ? shifted - ACC_W'(dur_eff) : shifted;
            quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_count_reg <= '0;
            loop_enable_reg <= 1'b0;
            rewind_reg      <= 1'b0;
            frame_reg       <= '0;
            prior_reg       <= '1;
            acc_reg         <= '0;
            paused_reg      <= 1'b0;
            finished_reg    <= 1'b0;
            loops_reg       <= '0;
            elapsed_reg     <= '0;
            adv_reg         <= 1'b0;
            valid_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_COUNT:   frame_count_reg <= cfg_wdata;
                    REG_LOOP_ENABLE:   loop_enable_reg <= cfg_wdata[0];
                    REG_REWIND_AT_END: rewind_reg      <= cfg_wdata[0];
                    default: begin
                        rewind_reg <= rewind_reg;
                    end
                endcase
            end
            frame_reg    <= frame_next;
            prior_reg    <= prior_next;
            acc_reg      <= acc_next;
            paused_reg   <= paused_next;
            finished_reg <= finished_next;
            loops_reg    <= loops_next;
            elapsed_reg  <= elapsed_next;
            adv_reg      <= adv_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= s_action;
            step_reg   <= s_step_us;
            slot_reg   <= s_slot;
            dur_in_reg <= s_duration_us;
        end
        rd_ok_reg <= (32'(frame_reg) < MAX_FRAMES) && valid_reg[frame_addr];
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        if (cmd.load_out) begin
            out_frame_reg   <= frame_reg;
            out_prior_reg   <= prior_reg;
            out_adv_reg     <= adv_reg;
            out_done_reg    <= finished_reg;
            out_halt_reg    <= paused_reg;
            out_loops_reg   <= loops_reg;
            out_elapsed_reg <= elapsed_reg;
        end
    end

    assign m_frame       = out_frame_reg;
    assign m_prior_frame = out_prior_reg;
    assign m_advanced    = out_adv_reg;
    assign m_done_flag   = out_done_reg;
    assign m_halted      = out_halt_reg;
    assign m_loops       = out_loops_reg;
    assign m_elapsed_us  = out_elapsed_reg;

endmodule

FILE: rtl/sprite_frame_sequencer.sv
// Top level of the sprite frame sequencer.
// Joins the controller (sprseq_ctrl) and the datapath (sprseq_dpath); uses sprseq_pkg.
//
//   Channel  Ports                                   Transfer when
//   input    s_action s_step_us s_slot s_duration_us s_valid && s_ready
//   result   m_frame .. m_elapsed_us                 m_valid && m_ready
//   config   cfg_index cfg_wdata                     cfg_wr_en
//
// Each item is handled alone. Non-tick actions, and ticks while paused or with no
// frames, go from decode straight to the output state; other ticks first pass the
// check state, and one that reaches a nonzero frame duration also runs the bit-serial
// remainder unit and a finish state. Once the result is loaded the block returns to
// idle and can take the next input. Reset is synchronous and needs no clearing pass.
// The next item is taken while a result waits in the output register; a stalled
// result only holds the block before it loads the next one.
module sprite_frame_sequencer
    import sprseq_pkg::*;
#(
    parameter int TIME_BITS  = 24
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [ACTION_W-1:0]       s_action,
    input  logic [STEP_W-1:0]         s_step_us,
    input  logic [SLOT_W-1:0]         s_slot,
    input  logic [DUR_IN_W-1:0]       s_duration_us,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [FRAME_W-1:0]        m_frame,
    output logic signed [PRIOR_W-1:0] m_prior_frame,
    output logic                      m_advanced,
    output logic                      m_done_flag,
    output logic                      m_halted,
    output logic [LOOP_W-1:0]         m_loops,
    output logic [ELAPSED_W-1:0]      m_elapsed_us
);

    cmd_t    cmd;
    status_t status;

    sprseq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sprseq_dpath #(
        .TIME_BITS  (TIME_BITS)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_action      (s_action),
        .s_step_us     (s_step_us),
        .s_slot        (s_slot),
        .s_duration_us (s_duration_us),
        .cmd           (cmd),
        .status        (status),
        .m_frame       (m_frame),
        .m_prior_frame (m_prior_frame),
        .m_advanced    (m_advanced),
        .m_done_flag   (m_done_flag),
        .m_halted      (m_halted),
        .m_loops       (m_loops),
        .m_elapsed_us  (m_elapsed_us)
    );

endmodule
